@@ hw/rtl/lbbc_pkg.sv @@
// ----------------------------------------------------------------------------
// lbbc_pkg: shared types and constants
// Request decode, slot geometry and operation codes for the byte-budget
// least-recently-used cache directory.
// ----------------------------------------------------------------------------
package lbbc_pkg;

   localparam int ENTRIES   = 64;
   localparam int SLOT_BITS = $clog2(ENTRIES);
   localparam int CNT_BITS  = $clog2(ENTRIES + 1);
   localparam int KEY_BITS  = 32;
   localparam int SIZE_BITS = 32;
   localparam int USED_BITS = 33;
   localparam int STAMP_BITS = 64;
   localparam int EVICT_BITS = 7;
   localparam int SLOT_OUT_BITS = 6;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_FLUSH  = 2'd3;

   // Decoded request handed from the front end to the engine
   typedef struct packed {
      logic [1:0]           op;
      logic                 refused;
      logic [KEY_BITS-1:0]  key;
      logic [SIZE_BITS-1:0] bytes;
   } cmd_type;

endpackage

@@ hw/rtl/lbbc_front.sv @@
// ----------------------------------------------------------------------------
// lbbc_front: request intake and classification
// Accepts requests, flags oversize inserts and queues them for the engine.
// ----------------------------------------------------------------------------
module lbbc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [1:0]                     req_tuser,  // action
   input  logic [63:0]                    req_tdata,  // key_tag, blob_bytes
   input  logic [lbbc_pkg::SIZE_BITS-1:0] max_entry_bytes,
   output logic                           cmd_valid,
   input  logic                           cmd_ready,
   output lbbc_pkg::cmd_type              cmd
);
   import lbbc_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    new_cmd;
   logic       push, pop;

   // Classify the incoming request
   always_comb begin
      new_cmd.op      = req_tuser;
      new_cmd.key     = req_tdata[31:0];
      new_cmd.bytes   = req_tdata[63:32];
      new_cmd.refused = (req_tuser == OP_INSERT) && (req_tdata[63:32] > max_entry_bytes);
   end

   assign req_tready = (count_ff != 2'd2);
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd        = slot_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;

   // Advance queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

@@ hw/rtl/lbbc_back.sv @@
// ----------------------------------------------------------------------------
// lbbc_back: cache directory engine
// Scans the slot table for key matches and eviction victims, updates the
// table and presents one result per request in an output register.
// ----------------------------------------------------------------------------
module lbbc_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_valid,
   output logic                           cmd_ready,
   input  lbbc_pkg::cmd_type              cmd,
   input  logic [lbbc_pkg::SIZE_BITS-1:0] max_total_bytes,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [79:0]                    rsp_tdata
);
   import lbbc_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MSCAN = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_LSCAN = 3'd3;
   localparam logic [2:0] ST_FREE  = 3'd4;
   localparam logic [2:0] ST_REPLY = 3'd5;

   localparam logic [CNT_BITS-1:0] CNT_END = CNT_BITS'(ENTRIES);

   // Slot storage
   logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
   logic [SIZE_BITS-1:0]  size_mem  [ENTRIES];
   logic [STAMP_BITS-1:0] stamp_mem [ENTRIES];
   logic [KEY_BITS-1:0]   rd_key_ff;
   logic [SIZE_BITS-1:0]  rd_size_ff;
   logic [STAMP_BITS-1:0] rd_stamp_ff;

   logic [2:0]            state_ff, state_in;
   cmd_type               cur_ff, cur_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  p_v_ff, p_v_in;
   logic [SLOT_BITS-1:0]  p_idx_ff, p_idx_in;
   logic                  found_ff, found_in;
   logic [SLOT_BITS-1:0]  fidx_ff, fidx_in;
   logic [SIZE_BITS-1:0]  fsize_ff, fsize_in;
   logic [STAMP_BITS-1:0] fstamp_ff, fstamp_in;
   logic [EVICT_BITS-1:0] evicted_ff, evicted_in;
   logic [USED_BITS-1:0]  bytes_ff, bytes_in;
   logic [STAMP_BITS-1:0] ctr_ff, ctr_in;
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [CNT_BITS-1:0]   vcount_ff, vcount_in;
   logic                  res_hit_ff, res_hit_in;
   logic                  res_stored_ff, res_stored_in;
   logic [SLOT_BITS-1:0]  res_slot_ff, res_slot_in;
   logic [SIZE_BITS-1:0]  res_size_ff, res_size_in;
   logic                  out_v_ff, out_v_in;
   logic [79:0]           out_d_ff, out_d_in;

   logic                  mem_we, stamp_we;
   logic [SLOT_BITS-1:0]  wr_addr;
   logic [STAMP_BITS-1:0] wr_stamp;
   logic                  scan_done, cur_valid, over_budget;

   assign cmd_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign scan_done  = (cnt_ff == CNT_END) && !p_v_ff;
   assign cur_valid  = p_v_ff && valid_ff[p_idx_ff];
   assign over_budget = ({1'b0, bytes_ff} + {2'b0, cur_ff.bytes}) >
                        {2'b0, max_total_bytes};

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      p_v_in        = 1'b0;
      p_idx_in      = cnt_ff[SLOT_BITS-1:0];
      found_in      = found_ff;
      fidx_in       = fidx_ff;
      fsize_in      = fsize_ff;
      fstamp_in     = fstamp_ff;
      evicted_in    = evicted_ff;
      bytes_in      = bytes_ff;
      ctr_in        = ctr_ff;
      valid_in      = valid_ff;
      vcount_in     = vcount_ff;
      res_hit_in    = res_hit_ff;
      res_stored_in = res_stored_ff;
      res_slot_in   = res_slot_ff;
      res_size_in   = res_size_ff;
      out_v_in      = out_v_ff && !rsp_tready;
      out_d_in      = out_d_ff;
      mem_we        = 1'b0;
      stamp_we      = 1'b0;
      wr_addr       = fidx_ff;
      wr_stamp      = ctr_ff + STAMP_BITS'(1);

      // Issue one slot read per cycle while a scan runs
      if ((state_ff == ST_MSCAN || state_ff == ST_LSCAN) && cnt_ff != CNT_END) begin
         p_v_in = 1'b1;
         cnt_in = cnt_ff + CNT_BITS'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cur_in        = cmd;
               found_in      = 1'b0;
               evicted_in    = '0;
               res_hit_in    = 1'b0;
               res_stored_in = 1'b0;
               res_slot_in   = '0;
               res_size_in   = '0;
               cnt_in        = '0;
               if (cmd.op == OP_FLUSH) begin
                  valid_in  = '0;
                  vcount_in = '0;
                  bytes_in  = '0;
                  state_in  = ST_REPLY;
               end else if (cmd.refused) begin
                  state_in = ST_REPLY;
               end else begin
                  state_in = ST_MSCAN;
               end
            end
         end
         ST_MSCAN: begin
            // Keep the first valid slot whose key matches
            if (cur_valid && !found_ff && rd_key_ff == cur_ff.key) begin
               found_in = 1'b1;
               fidx_in  = p_idx_ff;
               fsize_in = rd_size_ff;
            end
            if (scan_done) begin
               state_in = ST_REPLY;
               case (cur_ff.op)
                  OP_LOOKUP: begin
                     if (found_ff) begin
                        ctr_in      = ctr_ff + STAMP_BITS'(1);
                        stamp_we    = 1'b1;
                        res_hit_in  = 1'b1;
                        res_slot_in = fidx_ff;
                        res_size_in = fsize_ff;
                     end
                  end
                  OP_REMOVE: begin
                     if (found_ff) begin
                        valid_in[fidx_ff] = 1'b0;
                        vcount_in   = vcount_ff - CNT_BITS'(1);
                        bytes_in    = bytes_ff - {1'b0, fsize_ff};
                        res_hit_in  = 1'b1;
                        res_slot_in = fidx_ff;
                     end
                  end
                  default: begin
                     // Insert: drop any same-key entry without counting it
                     if (found_ff) begin
                        valid_in[fidx_ff] = 1'b0;
                        vcount_in = vcount_ff - CNT_BITS'(1);
                        bytes_in  = bytes_ff - {1'b0, fsize_ff};
                     end
                     state_in = ST_CHECK;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            found_in = 1'b0;
            cnt_in   = '0;
            if ((over_budget && vcount_ff != '0) || vcount_ff == CNT_END) begin
               state_in = ST_LSCAN;
            end else begin
               state_in = ST_FREE;
            end
         end
         ST_LSCAN: begin
            // Track the oldest stamp, lowest slot on a tie
            if (cur_valid && (!found_ff || rd_stamp_ff < fstamp_ff)) begin
               found_in  = 1'b1;
               fidx_in   = p_idx_ff;
               fsize_in  = rd_size_ff;
               fstamp_in = rd_stamp_ff;
            end
            if (scan_done) begin
               valid_in[fidx_ff] = 1'b0;
               vcount_in  = vcount_ff - CNT_BITS'(1);
               bytes_in   = bytes_ff - {1'b0, fsize_ff};
               evicted_in = evicted_ff + EVICT_BITS'(1);
               state_in   = ST_CHECK;
            end
         end
         ST_FREE: begin
            // Walk to the lowest free slot and store there
            if (!valid_ff[cnt_ff[SLOT_BITS-1:0]]) begin
               wr_addr       = cnt_ff[SLOT_BITS-1:0];
               mem_we        = 1'b1;
               stamp_we      = 1'b1;
               valid_in[cnt_ff[SLOT_BITS-1:0]] = 1'b1;
               vcount_in     = vcount_ff + CNT_BITS'(1);
               ctr_in        = ctr_ff + STAMP_BITS'(1);
               bytes_in      = bytes_ff + {1'b0, cur_ff.bytes};
               res_stored_in = 1'b1;
               res_slot_in   = cnt_ff[SLOT_BITS-1:0];
               state_in      = ST_REPLY;
            end else begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end
         end
         ST_REPLY: begin
            if (!out_v_ff || rsp_tready) begin
               out_v_in = 1'b1;
               out_d_in = {bytes_ff, evicted_ff, res_size_ff,
                           SLOT_OUT_BITS'(res_slot_ff), res_stored_ff, res_hit_ff};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         p_v_ff    <= 1'b0;
         valid_ff  <= '0;
         vcount_ff <= '0;
         bytes_ff  <= '0;
         ctr_ff    <= '0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         p_v_ff    <= p_v_in;
         valid_ff  <= valid_in;
         vcount_ff <= vcount_in;
         bytes_ff  <= bytes_in;
         ctr_ff    <= ctr_in;
         out_v_ff  <= out_v_in;
      end
   end

   // Hold working payload
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      cnt_ff        <= cnt_in;
      p_idx_ff      <= p_idx_in;
      found_ff      <= found_in;
      fidx_ff       <= fidx_in;
      fsize_ff      <= fsize_in;
      fstamp_ff     <= fstamp_in;
      evicted_ff    <= evicted_in;
      res_hit_ff    <= res_hit_in;
      res_stored_ff <= res_stored_in;
      res_slot_ff   <= res_slot_in;
      res_size_ff   <= res_size_in;
      out_d_ff      <= out_d_in;
   end

   // Slot memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[wr_addr]  <= cur_ff.key;
         size_mem[wr_addr] <= cur_ff.bytes;
      end
      if (stamp_we) begin
         stamp_mem[wr_addr] <= wr_stamp;
      end
      rd_key_ff   <= key_mem[cnt_ff[SLOT_BITS-1:0]];
      rd_size_ff  <= size_mem[cnt_ff[SLOT_BITS-1:0]];
      rd_stamp_ff <= stamp_mem[cnt_ff[SLOT_BITS-1:0]];
   end

endmodule

@@ hw/rtl/lru_byte_budget_cache_top.sv @@
// ----------------------------------------------------------------------------
// lru_byte_budget_cache_top: size-aware LRU cache directory
// Register port, request intake queue and directory engine.
// ----------------------------------------------------------------------------
//   Channel   Direction  Carries
//   req_*     in         action (tuser), key_tag and blob_bytes (tdata)
//   rsp_*     out        hit, stored, slot, entry_size, evicted_count, used_bytes
//   csr_*     in/out     max_total_bytes at 0x0, max_entry_bytes at 0x4
//
// Flush and refused inserts skip the table scans; lookup and remove take one
// scan of the slot table. An insert takes one scan plus one scan per eviction
// plus a walk to the lowest free slot. The single memory read port reads one
// slot per cycle. Reset is synchronous and clears the table at once. A
// two-deep request queue keeps taking requests, until it is full, while the
// engine works or a result waits on rsp_tready.
module lru_byte_budget_cache_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] action
   input  logic [63:0] req_tdata,   // [31:0] key_tag, [63:32] blob_bytes
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [0] hit, [1] stored, [7:2] slot,
                                    // [39:8] entry_size, [46:40] evicted_count,
                                    // [79:47] used_bytes
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lbbc_pkg::*;

   localparam logic [SIZE_BITS-1:0] TOTAL_RESET = SIZE_BITS'(268435456);
   localparam logic [SIZE_BITS-1:0] ENTRY_RESET = SIZE_BITS'(16777216);

   logic [SIZE_BITS-1:0] total_ff, total_in;
   logic [SIZE_BITS-1:0] entry_ff, entry_in;
   logic                 csr_wr;
   logic                 cmd_valid, cmd_ready;
   cmd_type              cmd;

   // Register writes and reads
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = csr_paddr[2] ? entry_ff : total_ff;

   always_comb begin
      total_in = total_ff;
      entry_in = entry_ff;
      if (csr_wr && !csr_paddr[2]) begin
         total_in = csr_pwdata;
      end
      if (csr_wr && csr_paddr[2]) begin
         entry_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOTAL_RESET;
         entry_ff <= ENTRY_RESET;
      end else begin
         total_ff <= total_in;
         entry_ff <= entry_in;
      end
   end

   lbbc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tuser       (req_tuser),
      .req_tdata       (req_tdata),
      .max_entry_bytes (entry_ff),
      .cmd_valid       (cmd_valid),
      .cmd_ready       (cmd_ready),
      .cmd             (cmd)
   );

   lbbc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd_ready       (cmd_ready),
      .cmd             (cmd),
      .max_total_bytes (total_ff),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata)
   );

endmodule
